@@ src/whmt_pkg.sv @@
package whmt_pkg;

    localparam int WIN_W    = 20;
    localparam int COIN_W   = 5;
    localparam int SENSOR_W = 5;
    localparam int OUT_W    = 32;
    localparam int CFG_W    = 20;
    localparam int IDX_W    = 1;

    localparam logic [IDX_W-1:0]  REG_WINDOW_TICKS = 1'b0;
    localparam logic [IDX_W-1:0]  REG_COIN_LEVEL   = 1'b1;

    localparam logic [WIN_W-1:0]  WINDOW_TICKS_RST = 20'd320;
    localparam logic [COIN_W-1:0] COIN_LEVEL_RST   = 5'd2;

    // controller -> datapath
    typedef struct packed {
        logic load;      // latch the item and start the window divide
        logic update;    // apply the item to the window state
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic div_done;  // window index is ready
        logic last;      // the held item ends the run
    } dp_stat_t;

endpackage

@@ src/whmt_div.sv @@
module whmt_div #(
    parameter int N   = 48,
    parameter int D_W = 20
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  logic [N-1:0]   dividend,
    input  logic [D_W-1:0] divisor,
    output logic           done,
    output logic [N-1:0]   quotient
);

    localparam int CW = $clog2(N + 1);

    logic [CW-1:0]  cnt_reg, cnt_next;
    logic           done_reg, done_next;
    logic [N-1:0]   quo_reg, quo_next;
    logic [D_W-1:0] rem_reg, rem_next;
    logic [D_W-1:0] dvs_reg, dvs_next;
    logic [D_W:0]   trial;
    logic           fits;

    // restoring division, one quotient bit per cycle
    always_comb
    begin
        trial     = {rem_reg, quo_reg[N-1]};
        fits      = trial >= {1'b0, dvs_reg};
        cnt_next  = cnt_reg;
        done_next = done_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            cnt_next  = CW'(N);
            done_next = 1'b0;
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
        end
        else if (cnt_reg != '0)
        begin
            cnt_next = cnt_reg - 1'b1;
            quo_next = {quo_reg[N-2:0], fits};
            rem_next = fits ? D_W'(trial - {1'b0, dvs_reg}) : trial[D_W-1:0];
            if (cnt_reg == CW'(1))
            begin
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

`ifndef SYNTHESIS
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> cnt_reg == '0)
        else $error("divider done while still iterating");
`endif

endmodule

@@ src/whmt_dp.sv @@
module whmt_dp #(
    parameter int SENSOR_COUNT = 31,
    parameter int TIME_BITS    = 48,
    parameter int COUNT_BITS   = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  whmt_pkg::dp_cmd_t             cmd,
    output whmt_pkg::dp_stat_t            stat,
    input  logic                          cfg_we,
    input  logic [whmt_pkg::IDX_W-1:0]    cfg_index,
    input  logic [whmt_pkg::CFG_W-1:0]    cfg_data,
    input  logic [TIME_BITS-1:0]          hit_time,
    input  logic [whmt_pkg::SENSOR_W-1:0] sensor_index,
    input  logic                          last_hit,
    output logic [whmt_pkg::OUT_W-1:0]    matched_windows
);
    import whmt_pkg::*;

    localparam int CNT_W = $clog2(SENSOR_COUNT + 1);
    localparam int CMP_W = (CNT_W > COIN_W) ? CNT_W : COIN_W;

    logic [WIN_W-1:0]        window_ticks_reg;
    logic [COIN_W-1:0]       coin_level_reg;
    logic [SENSOR_W-1:0]     sensor_reg;
    logic                    last_reg;
    logic [TIME_BITS-1:0]    current_window_reg, current_window_next;
    logic                    window_valid_reg, window_valid_next;
    logic [SENSOR_COUNT-1:0] sensor_mask_reg, sensor_mask_next;
    logic [CNT_W-1:0]        dcnt_reg, dcnt_next;
    logic [COUNT_BITS-1:0]   match_count_reg, match_count_next;
    logic [OUT_W-1:0]        out_data_reg;

    logic [WIN_W-1:0]         divisor;
    logic                     div_done;
    logic [TIME_BITS-1:0]     win_idx;
    logic [SENSOR_COUNT-1:0]  hit_onehot;
    logic                     same_window;
    logic                     close_match;
    logic                     last_match;
    logic [SENSOR_COUNT-1:0]  mask_new;
    logic [CNT_W-1:0]         dcnt_new;
    logic [1:0]               inc;
    logic [COUNT_BITS:0]      count_sum;
    logic [COUNT_BITS-1:0]    count_sat;

    assign divisor = (window_ticks_reg == '0) ? WIN_W'(1) : window_ticks_reg;

    whmt_div #(
        .N   (TIME_BITS),
        .D_W (WIN_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.load),
        .dividend (hit_time),
        .divisor  (divisor),
        .done     (div_done),
        .quotient (win_idx)
    );

    always_comb
    begin
        for (int i = 0; i < SENSOR_COUNT; i++)
        begin
            hit_onehot[i] = (32'(sensor_reg) == 32'(i));
        end
    end

    // a hit in another window closes the open one and starts fresh
    always_comb
    begin
        same_window = window_valid_reg && (win_idx == current_window_reg);
        close_match = window_valid_reg && !same_window &&
                      (CMP_W'(dcnt_reg) == CMP_W'(coin_level_reg));
        mask_new    = (same_window ? sensor_mask_reg : '0) | hit_onehot;
        dcnt_new    = (same_window ? dcnt_reg : '0) +
                      CNT_W'(|(hit_onehot & ~(same_window ? sensor_mask_reg : '0)));
        last_match  = last_reg && (CMP_W'(dcnt_new) == CMP_W'(coin_level_reg));
        inc         = 2'(close_match) + 2'(last_match);
        count_sum   = {1'b0, match_count_reg} + (COUNT_BITS+1)'(inc);
        count_sat   = count_sum[COUNT_BITS] ? '1 : count_sum[COUNT_BITS-1:0];
    end

    always_comb
    begin
        current_window_next = current_window_reg;
        window_valid_next   = window_valid_reg;
        sensor_mask_next    = sensor_mask_reg;
        dcnt_next           = dcnt_reg;
        match_count_next    = match_count_reg;
        if (cmd.update)
        begin
            if (last_reg)
            begin
                current_window_next = '0;
                window_valid_next   = 1'b0;
                sensor_mask_next    = '0;
                dcnt_next           = '0;
                match_count_next    = '0;
            end
            else
            begin
                current_window_next = win_idx;
                window_valid_next   = 1'b1;
                sensor_mask_next    = mask_new;
                dcnt_next           = dcnt_new;
                match_count_next    = count_sat;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_ticks_reg   <= WINDOW_TICKS_RST;
            coin_level_reg     <= COIN_LEVEL_RST;
            current_window_reg <= '0;
            window_valid_reg   <= 1'b0;
            sensor_mask_reg    <= '0;
            dcnt_reg           <= '0;
            match_count_reg    <= '0;
        end
        else
        begin
            if (cfg_we && cfg_index == REG_WINDOW_TICKS)
            begin
                window_ticks_reg <= cfg_data[WIN_W-1:0];
            end
            if (cfg_we && cfg_index == REG_COIN_LEVEL)
            begin
                coin_level_reg <= cfg_data[COIN_W-1:0];
            end
            current_window_reg <= current_window_next;
            window_valid_reg   <= window_valid_next;
            sensor_mask_reg    <= sensor_mask_next;
            dcnt_reg           <= dcnt_next;
            match_count_reg    <= match_count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            sensor_reg <= sensor_index;
            last_reg   <= last_hit;
        end
        if (cmd.update && last_reg)
        begin
            out_data_reg <= OUT_W'(count_sat);
        end
    end

    assign stat.div_done   = div_done;
    assign stat.last       = last_reg;
    assign matched_windows = out_data_reg;

`ifndef SYNTHESIS
    a_dcnt_mask: assert property (@(posedge clk) disable iff (!rst_n)
        32'(dcnt_reg) == $countones(sensor_mask_reg))
        else $error("distinct count out of step with sensor mask");
    a_run_clear: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.update && last_reg |=> match_count_reg == '0 && !window_valid_reg)
        else $error("state not cleared after last item");
`endif

endmodule

@@ src/whmt_ctrl.sv @@
module whmt_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  logic               out_ready,
    input  whmt_pkg::dp_stat_t stat,
    output whmt_pkg::dp_cmd_t  cmd
);
    import whmt_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_DIV    = 3'b010,
        ST_UPDATE = 3'b100
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        cmd.load       = 1'b0;
        cmd.update     = 1'b0;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (stat.div_done)
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                // hold a last item until the previous result is taken
                if (!(stat.last && out_valid_reg))
                begin
                    cmd.update = 1'b1;
                    state_next = ST_IDLE;
                    if (stat.last)
                    begin
                        out_valid_next = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

`ifndef SYNTHESIS
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.update && stat.last |-> !out_valid_reg)
        else $error("result overwritten before it was taken");
`endif

endmodule

@@ src/windowed_hit_multiplicity_trigger.sv @@
// Fixed-window coincidence trigger. Hits (time stamp in ticks, sensor index)
// arrive in time order; time is cut into windows of window_ticks ticks
// aligned to multiples of window_ticks (a length of 0 acts as 1). A window
// whose count of distinct sensors equals coin_level exactly adds one to a
// saturating match counter when it closes. A hit with last_hit set closes
// its own window, emits the counter as one item on the output and clears
// all run state; other hits produce no output. Sensor indexes at or above
// SENSOR_COUNT open and close windows but mark no sensor. The bit-serial
// divider forms hit_time / window_ticks one quotient bit per cycle. A finished
// result sits in an output register, so the next item is accepted while it
// waits; only a second last hit stalls until the first result is taken.
// Write configuration only while the block is idle.
module windowed_hit_multiplicity_trigger #(
    parameter int SENSOR_COUNT = 31,
    parameter int TIME_BITS    = 48,
    parameter int COUNT_BITS   = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [whmt_pkg::IDX_W-1:0]    cfg_index,
    input  logic [whmt_pkg::CFG_W-1:0]    cfg_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [TIME_BITS-1:0]          hit_time,
    input  logic [whmt_pkg::SENSOR_W-1:0] sensor_index,
    input  logic                          last_hit,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [whmt_pkg::OUT_W-1:0]    matched_windows
);
    import whmt_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    whmt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    whmt_dp #(
        .SENSOR_COUNT (SENSOR_COUNT),
        .TIME_BITS    (TIME_BITS),
        .COUNT_BITS   (COUNT_BITS)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .stat            (stat),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .hit_time        (hit_time),
        .sensor_index    (sensor_index),
        .last_hit        (last_hit),
        .matched_windows (matched_windows)
    );

endmodule

@@ test/windowed_hit_multiplicity_trigger_tb.sv @@
`timescale 1ns / 100ps

module windowed_hit_multiplicity_trigger_tb;
    import whmt_pkg::*;

    localparam int STAMP_W = 48;
    localparam int SENSORS = 31;
    localparam logic [STAMP_W-1:0] STAMP_MAX = '1;

    typedef struct {
        logic [STAMP_W-1:0]  stamp;
        logic [SENSOR_W-1:0] sensor;
        logic                ends_run;
    } hit_item_t;

    logic                clk          = 1'b0;
    logic                rst_n        = 1'b0;
    logic                cfg_we       = 1'b0;
    logic [IDX_W-1:0]    cfg_index    = '0;
    logic [CFG_W-1:0]    cfg_data     = '0;
    logic                in_valid     = 1'b0;
    logic                in_ready;
    logic [STAMP_W-1:0]  hit_time     = '0;
    logic [SENSOR_W-1:0] sensor_index = '0;
    logic                last_hit     = 1'b0;
    logic                out_valid;
    logic                out_ready    = 1'b0;
    logic [OUT_W-1:0]    matched_windows;

    // trigger state as the hits should leave it
    logic [WIN_W-1:0]    win_len     = WINDOW_TICKS_RST;
    logic [COIN_W-1:0]   coin        = COIN_LEVEL_RST;
    logic [STAMP_W-1:0]  open_window = '0;
    logic                window_open = 1'b0;
    logic [SENSORS-1:0]  seen_mask   = '0;
    logic [OUT_W-1:0]    match_count = '0;

    hit_item_t        hit_queue[$];
    logic [OUT_W-1:0] count_queue[$];
    int               queued       = 0;
    int               fail_count   = 0;
    int               send_wait    = 0;
    int               ready_wait   = 0;
    bit               idle_on      = 1'b1;
    bit               hold_request = 1'b0;

    always #1 clk = ~clk;

    windowed_hit_multiplicity_trigger uut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .hit_time        (hit_time),
        .sensor_index    (sensor_index),
        .last_hit        (last_hit),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .matched_windows (matched_windows)
    );

    function automatic logic [STAMP_W-1:0] eff_window();
        return (win_len == '0) ? STAMP_W'(1) : STAMP_W'(win_len);
    endfunction

    function automatic void close_window();
        if (window_open && $countones(seen_mask) == coin && match_count != '1)
            match_count = match_count + 1'b1;
        seen_mask   = '0;
        window_open = 1'b0;
    endfunction

    // returns 1 when the hit ends a run; total then holds the reported count
    function automatic bit apply_hit(input logic [STAMP_W-1:0] stamp,
                                     input logic [SENSOR_W-1:0] sensor,
                                     input logic ends_run,
                                     output logic [OUT_W-1:0] total);
        logic [STAMP_W-1:0] win_index;
        win_index = stamp / eff_window();
        total     = '0;
        if (window_open && win_index != open_window)
            close_window();
        if (!window_open)
        begin
            open_window = win_index;
            window_open = 1'b1;
            seen_mask   = '0;
        end
        if (sensor < SENSORS)
            seen_mask[sensor] = 1'b1;
        if (!ends_run)
            return 1'b0;
        close_window();
        total       = match_count;
        open_window = '0;
        match_count = '0;
        return 1'b1;
    endfunction

    task automatic push_hit(logic [STAMP_W-1:0] stamp, logic [SENSOR_W-1:0] sensor,
                            bit ends_run);
        hit_item_t item;
        item.stamp    = stamp;
        item.sensor   = sensor;
        item.ends_run = ends_run;
        hit_queue.insert(hit_queue.size(), item);
        queued++;
    endtask

    // one run of windows, each holding a chosen number of distinct sensors
    task automatic queue_run(int windows, bit with_last);
        logic [STAMP_W-1:0]  len;
        logic [STAMP_W-1:0]  stamp;
        logic [STAMP_W-1:0]  wstart;
        logic [63:0]         wend;
        logic [SENSOR_W-1:0] sensor;
        int                  order[SENSORS];
        int                  k;
        int                  extras;
        int                  n;
        int                  j;
        int                  tmp;
        len = eff_window();
        if ($urandom_range(0, 3) == 0)
            stamp = STAMP_W'($urandom_range(0, 5000));
        else
            stamp = STAMP_W'({$urandom, $urandom});
        for (int w = 0; w < windows; w++)
        begin
            wstart = (stamp / len) * len;
            wend   = 64'(wstart) + 64'(len) - 64'd1;
            if (wend > 64'(STAMP_MAX))
                wend = 64'(STAMP_MAX);
            if ($urandom_range(0, 1) == 1)
                k = int'(coin);
            else
                k = $urandom_range(0, (coin > 29) ? 31 : int'(coin) + 2);
            for (int i = 0; i < SENSORS; i++)
                order[i] = i;
            for (int i = SENSORS - 1; i > 0; i--)
            begin
                j        = $urandom_range(0, i);
                tmp      = order[i];
                order[i] = order[j];
                order[j] = tmp;
            end
            extras = $urandom_range(0, 2);
            if (k == 0 && extras == 0)
                extras = 1;
            n = k + extras;
            for (int h = 0; h < n; h++)
            begin
                if (h < k)
                    sensor = SENSOR_W'(order[h]);
                else if (k == 0 || $urandom_range(0, 1) == 0)
                    sensor = SENSOR_W'(SENSORS);
                else
                    sensor = SENSOR_W'(order[$urandom_range(0, k - 1)]);
                stamp = stamp + $urandom_range(0, 32'((wend - 64'(stamp)) / (n - h)));
                // stray hit anywhere in time
                if ($urandom_range(0, 24) == 0)
                    push_hit(STAMP_W'({$urandom, $urandom}),
                             SENSOR_W'($urandom_range(0, 31)), 1'b0);
                push_hit(stamp, sensor, with_last && w == windows - 1 && h == n - 1);
            end
            // advance to the next or a later window, now and then step back
            if ($urandom_range(0, 9) == 0)
                stamp = wstart - len * $urandom_range(1, 2);
            else
                stamp = wstart + len * $urandom_range(1, 3);
        end
    endtask

    task automatic queue_runs(int budget, int max_windows, bit close_last);
        int start;
        start = queued;
        while (queued - start < budget)
            queue_run($urandom_range(1, max_windows), 1'b1);
        if (!close_last)
            queue_run(2, 1'b0);
    endtask

    task automatic write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
        if (idx == REG_WINDOW_TICKS)
            win_len = value[WIN_W-1:0];
        else if (idx == REG_COIN_LEVEL)
            coin = value[COIN_W-1:0];
    endtask

    task automatic set_config(logic [WIN_W-1:0] ticks, logic [COIN_W-1:0] level);
        write_reg(REG_WINDOW_TICKS, CFG_W'(ticks));
        write_reg(REG_COIN_LEVEL, CFG_W'(level));
    endtask

    // wait for every count, then let a hit without a result finish its divide
    task automatic settle();
        while (hit_queue.size() != 0 || in_valid || count_queue.size() != 0)
            @(negedge clk);
        repeat (80) @(negedge clk);
    endtask

    always @(posedge clk)
    begin : driver
        hit_item_t        item;
        logic [OUT_W-1:0] total;
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                if (apply_hit(hit_time, sensor_index, last_hit, total))
                    count_queue.insert(count_queue.size(), total);
            end
            if (!in_valid || in_ready)
            begin
                if (send_wait > 0)
                begin
                    send_wait--;
                    in_valid <= 1'b0;
                end
                else if (hit_queue.size() != 0)
                begin
                    item         = hit_queue.pop_front();
                    in_valid     <= 1'b1;
                    hit_time     <= item.stamp;
                    sensor_index <= item.sensor;
                    last_hit     <= item.ends_run;
                    if (idle_on && $urandom_range(0, 7) == 0)
                        send_wait = $urandom_range(1, 15);
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk)
    begin : monitor
        logic [OUT_W-1:0] want;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (count_queue.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("unexpected item: matched_windows=%0d", matched_windows);
                    fail_count++;
                end
                else
                begin
                    want = count_queue.pop_front();
                    if (matched_windows !== want)
                    begin
                        if (fail_count < 10)
                            $display("matched_windows: expected %0d, got %0d",
                                     want, matched_windows);
                        fail_count++;
                    end
                end
            end
            if (hold_request)
            begin
                hold_request = 1'b0;
                ready_wait   = 1000;
                out_ready    <= 1'b0;
            end
            else if (ready_wait > 0)
            begin
                ready_wait--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
                if (idle_on && $urandom_range(0, 5) == 0)
                    ready_wait = $urandom_range(1, 15);
            end
        end
    end

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset registers: windows of 320 ticks, pairs match
        push_hit(0, 0, 1'b0);
        push_hit(5, 1, 1'b0);
        push_hit(319, 1, 1'b0);
        push_hit(320, 30, 1'b0);
        push_hit(639, 31, 1'b1);
        // a step back in time still closes the open window
        push_hit(1000, 2, 1'b0);
        push_hit(10, 3, 1'b0);
        push_hit(11, 4, 1'b1);
        push_hit(STAMP_MAX, 0, 1'b0);
        push_hit(STAMP_MAX, 30, 1'b1);
        push_hit(0, 31, 1'b1);
        settle();

        // zero length acts as one tick; out-of-range-only windows match level 0
        set_config(0, 0);
        push_hit(7, 31, 1'b0);
        push_hit(8, 31, 1'b0);
        push_hit(8, 5, 1'b0);
        push_hit(9, 31, 1'b1);
        settle();

        // change the window length while a window is open
        set_config(100, 1);
        push_hit(120, 3, 1'b0);
        settle();
        write_reg(REG_WINDOW_TICKS, 60);
        push_hit(121, 4, 1'b0);
        push_hit(125, 5, 1'b1);
        settle();

        set_config(WINDOW_TICKS_RST, COIN_LEVEL_RST);
        queue_runs(150, 6, 1'b1);
        settle();
        set_config(1, 1);
        queue_runs(150, 6, 1'b1);
        settle();
        set_config(0, 0);
        queue_runs(150, 6, 1'b1);
        settle();
        set_config(16, 3);
        queue_runs(150, 6, 1'b1);
        settle();
        set_config(20'hFFFFF, 31);
        queue_runs(150, 3, 1'b1);
        settle();
        set_config(WIN_W'($urandom_range(1, 4096)), COIN_W'($urandom_range(0, 31)));
        queue_runs(150, 6, 1'b1);
        settle();
        // leave the last window open across the next register change
        set_config(WIN_W'($urandom_range(1, 20'hFFFFF)), COIN_W'($urandom_range(0, 31)));
        queue_runs(150, 6, 1'b0);
        settle();
        set_config(WIN_W'($urandom_range(1, 4096)), COIN_W'($urandom_range(1, 4)));
        queue_runs(150, 6, 1'b1);
        settle();

        // hold the result side so finished counts back up into the input
        set_config(200, 2);
        hold_request = 1'b1;
        queue_runs(40, 1, 1'b1);
        settle();

        idle_on = 1'b0;
        set_config(64, 4);
        queue_runs(150, 6, 1'b1);
        settle();
        repeat (60) @(negedge clk);

        if (fail_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    initial
    begin
        #1_200_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
